// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SWMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/swmf_pkg.sv =====
`default_nettype none

package swmf_pkg;

    localparam int SAMPLE_W = 10;
    localparam int DATA_W   = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DONE
    } swmf_state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;   // replace the oldest entry with the new sample
        logic sort;   // run one compare-exchange phase
        logic phase;  // parity of the lower cell of each pair
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sliding_window_median_filter.sv =====
// Channel   Direction  Signals                      Contents
// s_        in         tvalid tready tdata tuser    one sample and its report request
// m_        out        tvalid tready tdata          one window median
//
// After acceptance the block is not ready again until it has replaced the
// oldest entry, run WINDOW compare-exchange phases over the cell chain, and
// handed the median over, when one was asked for.
// Reset clears every entry to zero and gives the cells distinct ages.
// A pending median stalls the block only when the next median is ready.

`default_nettype none

module sliding_window_median_filter #(
    parameter int WINDOW = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [9:0] sample, [15:10] zero
    input  wire  [0:0]  s_tuser,   // [0] want_median
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [9:0] median, [15:10] zero
);
    import swmf_pkg::*;

    localparam int AGE_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] LAST_PHASE = CNT_W'(WINDOW - 1);

    // The window lives in a chain of cells kept in sorted order. Each cell
    // carries an age so that the oldest entry is found locally and replaced
    // in place. The one entry left out of order is moved into place by
    // WINDOW odd-even transposition phases, after which the middle cells
    // hold the median.

    swmf_state_t          state_reg;
    swmf_state_t          state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 want_reg;
    logic                 want_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SAMPLE_W-1:0]  out_data_reg;
    logic [SAMPLE_W-1:0]  out_data_next;

    cell_ctrl_t           ctrl;
    logic                 accept;
    logic                 out_load;
    logic [SAMPLE_W-1:0]  median;

    logic [SAMPLE_W-1:0]  value_w [WINDOW];
    logic [AGE_W-1:0]     age_w   [WINDOW];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            localparam int LEFT  = (gi > 0) ? gi - 1 : gi;
            localparam int RIGHT = (gi < WINDOW - 1) ? gi + 1 : gi;
            swmf_cell #(
                .WINDOW (WINDOW),
                .INDEX  (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .sample      (s_tdata[SAMPLE_W-1:0]),
                .left_value  (value_w[LEFT]),
                .left_age    (age_w[LEFT]),
                .right_value (value_w[RIGHT]),
                .right_age   (age_w[RIGHT]),
                .value       (value_w[gi]),
                .age         (age_w[gi])
            );
        end
    endgenerate

    // Middle of the sorted chain; an even window averages the middle pair.
    generate
        if ((WINDOW % 2) == 1)
        begin : g_odd
            assign median = value_w[(WINDOW - 1) / 2];
        end
        else
        begin : g_even
            logic [SAMPLE_W:0] pair_sum;
            assign pair_sum = {1'b0, value_w[WINDOW / 2]} + {1'b0, value_w[WINDOW / 2 - 1]};
            assign median   = pair_sum[SAMPLE_W:1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            want_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            want_reg      <= want_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        want_next  = want_reg;
        out_load   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_SORT;
                    count_next = '0;
                    want_next  = s_tuser[0];
                end
            end
            ST_SORT:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_PHASE)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!want_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept     = s_tvalid && s_tready;
    assign ctrl.load  = accept;
    assign ctrl.sort  = (state_reg == ST_SORT);
    assign ctrl.phase = count_reg[0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = median;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(DATA_W - SAMPLE_W)'(0), out_data_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/swmf_cell.sv =====
`default_nettype none

module swmf_cell #(
    parameter int WINDOW = 32,
    parameter int INDEX  = 0
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  swmf_pkg::cell_ctrl_t                 ctrl,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]        sample,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]        left_value,
    input  wire  [$clog2(WINDOW)-1:0]            left_age,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]        right_value,
    input  wire  [$clog2(WINDOW)-1:0]            right_age,
    output logic [swmf_pkg::SAMPLE_W-1:0]        value,
    output logic [$clog2(WINDOW)-1:0]            age
);
    import swmf_pkg::*;

    localparam int  AGE_W     = $clog2(WINDOW);
    localparam bit  POS_ODD   = (INDEX % 2) == 1;
    localparam bit  HAS_LEFT  = INDEX > 0;
    localparam bit  HAS_RIGHT = INDEX < WINDOW - 1;
    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WINDOW - 1);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic [AGE_W-1:0]    age_reg;
    logic [AGE_W-1:0]    age_next;
    logic                is_low;
    logic                is_high;

    // In a phase, this cell is the lower member of a pair when its parity
    // matches the phase, else the upper one, where that neighbour exists.
    assign is_low  = HAS_RIGHT && (ctrl.phase == POS_ODD);
    assign is_high = HAS_LEFT && (ctrl.phase != POS_ODD);

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.load)
        begin
            if (age_reg == OLDEST)
            begin
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                age_next = age_reg + 1'b1;
            end
        end
        else if (ctrl.sort)
        begin
            if (is_low && (value_reg > right_value))
            begin
                value_next = right_value;
                age_next   = right_age;
            end
            else if (is_high && (left_value > value_reg))
            begin
                value_next = left_value;
                age_next   = left_age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= AGE_W'(INDEX);
        end
        else
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swmf_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module swmf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire [0:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    // An accepted item keeps the input side closed for the next cycle.
    `SWMF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // Padding above the median is always zero.
    `SWMF_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[15:10] == 6'd0)

    // A stalled median stays offered and unchanged.
    `SWMF_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `SWMF_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (.*);

`default_nettype wire

// ===== bench/sliding_window_median_filter_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_median_filter_tb;

    import swmf_pkg::SAMPLE_W;
    import swmf_pkg::DATA_W;

    localparam int WINDOW      = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WAIT   = 4 * WINDOW;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;

    // Our own copy of the sample window and its write pointer.
    logic [SAMPLE_W-1:0] window_entries [WINDOW];
    int                  write_slot;
    logic [SAMPLE_W-1:0] median_queue [$];

    int                  mismatches;
    int                  cycle_count;
    bit                  quiet_tail;
    logic [SAMPLE_W-1:0] cluster_center;

    sliding_window_median_filter #(
        .WINDOW(WINDOW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Median of the whole window; the even case averages the middle pair in
    // one extra bit and drops the low bit, which floors it.
    function automatic logic [SAMPLE_W-1:0] window_median();
        logic [SAMPLE_W-1:0] ordered [WINDOW];
        logic [SAMPLE_W-1:0] held;
        logic [SAMPLE_W:0]   pair_sum;
        int                  k;
        ordered = window_entries;
        for (int n = 1; n < WINDOW; n++)
        begin
            held = ordered[n];
            k = n;
            while (k > 0 && ordered[k-1] > held)
            begin
                ordered[k] = ordered[k-1];
                k--;
            end
            ordered[k] = held;
        end
        if (WINDOW % 2 != 0)
            return ordered[(WINDOW - 1) / 2];
        pair_sum = {1'b0, ordered[WINDOW / 2]} + {1'b0, ordered[WINDOW / 2 - 1]};
        return pair_sum[SAMPLE_W:1];
    endfunction

    // Stores an accepted sample and, when a report was asked, queues the
    // median that the block must hand over.
    task automatic store_sample(input logic [SAMPLE_W-1:0] value, input logic report);
        window_entries[write_slot] = value;
        write_slot = (write_slot + 1) % WINDOW;
        if (report)
            median_queue.push_back(window_median());
    endtask

    // Presents one item and returns right after the edge that accepts it.
    // Ready is looked at on the falling edge, where nothing is in motion, so
    // the item is certain to be taken at the following rising edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic report);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - SAMPLE_W){1'b0}}, value};
        s_tuser  <= report;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        store_sample(value, report);
        @(posedge clk);
    endtask

    task automatic idle_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sample values drawn from a mix: uniform, the range ends, a slowly
    // moving cluster that produces many ties, and single-bit patterns.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return 10'($urandom_range(0, 1023));
        if (mode < 6)
        begin
            case ($urandom_range(0, 3))
                0: return 10'd0;
                1: return 10'd1;
                2: return 10'd1022;
                default: return 10'd1023;
            endcase
        end
        if (mode < 9)
        begin
            if ($urandom_range(0, 15) == 0)
                cluster_center = 10'($urandom_range(0, 1023));
            return cluster_center ^ 10'($urandom_range(0, 7));
        end
        return 10'(1 << $urandom_range(0, SAMPLE_W - 1));
    endfunction

    // A window of zeros gives zero, and zeros keep dominating while only a
    // few entries have been overwritten.
    task automatic test_zero_window();
        send_sample(10'd0, 1'b1);
        send_sample(10'd1023, 1'b0);
        send_sample(10'd1023, 1'b1);
    endtask

    // With sixteen entries at full scale the middle pair is zero and 1023,
    // so the floor matters. One more sample puts 1022 and 1023 in the
    // middle, whose sum needs the eleventh bit.
    task automatic test_even_middle_pair();
        for (int i = 0; i < 14; i++)
            send_sample(10'd1023, i == 6 || i == 13);
        send_sample(10'd1022, 1'b1);
        send_sample(10'd1, 1'b1);
        send_sample(10'h2AA, 1'b1);
        send_sample(10'h155, 1'b1);
    endtask

    // Long random stream with gaps on the input side and stalls on the
    // output side; reports come in runs and long quiet stretches.
    task automatic test_random_stream(input int count);
        int report_odds;
        report_odds = 50;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                report_odds = $urandom_range(0, 4) * 25;
            if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 8));
            send_sample(pick_sample(), $urandom_range(1, 100) <= report_odds);
        end
    endtask

    // Back-to-back items with the receiver always ready.
    task automatic test_steady_tail(input int count);
        quiet_tail = 1'b1;
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
    endtask

    // Receiver: stalls in random bursts until the final part of the run.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Each median is compared on the falling edge before the rising edge
    // that transfers it.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (median_queue.size() == 0)
            begin
                $display("%0t: unexpected median, expected none, actual %0d",
                         $time, m_tdata[SAMPLE_W-1:0]);
                mismatches++;
            end
            else if (m_tdata[SAMPLE_W-1:0] !== median_queue[0])
            begin
                $display("%0t: median mismatch, expected %0d, actual %0d",
                         $time, median_queue[0], m_tdata[SAMPLE_W-1:0]);
                mismatches++;
                void'(median_queue.pop_front());
            end
            else
                void'(median_queue.pop_front());
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatches     = 0;
        quiet_tail     = 1'b0;
        write_slot     = 0;
        cluster_center = 10'd512;
        foreach (window_entries[i])
            window_entries[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_window();
        test_even_middle_pair();
        test_random_stream(700);
        test_steady_tail(150);

        while (median_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_cell.sv
hw/rtl/sliding_window_median_filter.sv
hw/rtl/swmf_checker.sv
bench/sliding_window_median_filter_tb.sv
